FILE: design/dset_pkg.sv
// Package for the depth-sorted entry table: codes, entry and cell-control types,
// stream widths and the default table size. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dset_pkg;

    localparam int DEF_CAPACITY = 512;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int RIDX_W   = 9;
    localparam int OCNT_W   = 10;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_REM_POS  = 3'd1,
        CMD_REM_TYPE = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] depth;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] kind;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_MARK   = 3'd2,
        CELL_SWAP   = 3'd3,
        CELL_ROTATE = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     parity;
        logic     use_type;
        t_entry   ent;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/dset_cell.sv
// One table cell: holds an entry plus alive and hit flags, trades with its neighbors.
// Depends on dset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dset_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 10
) (
    input  wire logic                i_clk,
    input  wire dset_pkg::t_cell_ctl i_ctl,
    input  wire logic [CNT_W-1:0]    i_count,
    input  wire dset_pkg::t_entry    i_lo_ent,
    input  wire logic                i_lo_gt,
    input  wire logic                i_lo_alive,
    input  wire dset_pkg::t_entry    i_hi_ent,
    input  wire logic                i_hi_alive,
    input  wire logic                i_hi_hit,
    output dset_pkg::t_entry         o_ent,
    output logic                     o_gt,
    output logic                     o_alive,
    output logic                     o_hit
);

    localparam logic ODD = 1'(IDX % 2);

    dset_pkg::t_entry r_ent, n_ent;
    logic             r_alive, n_alive;
    logic             r_hit, n_hit;
    logic             w_occ, w_at_end, w_match, w_lower;

    assign w_occ    = CNT_W'(IDX) < i_count;
    assign w_at_end = CNT_W'(IDX) == i_count;
    assign w_match  = (r_ent.x == i_ctl.ent.x) && (r_ent.y == i_ctl.ent.y) &&
                      (!i_ctl.use_type || (r_ent.kind == i_ctl.ent.kind));
    assign w_lower  = i_ctl.parity == ODD;
    assign o_gt     = w_occ && (r_ent.depth > i_ctl.ent.depth);
    assign o_ent    = r_ent;
    assign o_alive  = r_alive;
    assign o_hit    = r_hit;

    always_comb begin
        n_ent   = r_ent;
        n_alive = r_alive;
        n_hit   = r_hit;
        case (i_ctl.op)
            dset_pkg::CELL_INSERT: begin
                if (i_lo_gt) begin
                    n_ent = i_lo_ent;
                end else if (o_gt || w_at_end) begin
                    n_ent = i_ctl.ent;
                end
            end
            dset_pkg::CELL_MARK: begin
                n_alive = w_occ && !w_match;
                n_hit   = w_occ && w_match;
            end
            dset_pkg::CELL_SWAP: begin
                n_hit = i_hi_hit;
                if (w_lower) begin
                    if (!r_alive && i_hi_alive) begin
                        n_ent   = i_hi_ent;
                        n_alive = 1'b1;
                    end
                end else begin
                    if (!i_lo_alive && r_alive) begin
                        n_ent   = i_lo_ent;
                        n_alive = 1'b0;
                    end
                end
            end
            dset_pkg::CELL_ROTATE: begin
                n_ent = i_hi_ent;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_alive <= n_alive;
        r_hit   <= n_hit;
    end

endmodule

`default_nettype wire

FILE: design/dset_chain.sv
// Row of table cells wired to their neighbors; the top cell wraps to cell 0 for rotation.
// Depends on dset_pkg and dset_cell.
`timescale 1ns / 1ps
`default_nettype none

module dset_chain #(
    parameter int CAPACITY = dset_pkg::DEF_CAPACITY,
    parameter int CNT_W    = 10
) (
    input  wire logic                i_clk,
    input  wire dset_pkg::t_cell_ctl i_ctl,
    input  wire logic [CNT_W-1:0]    i_count,
    output dset_pkg::t_entry         o_head_ent,
    output logic                     o_head_hit
);

    dset_pkg::t_entry w_ent   [CAPACITY];
    logic             w_gt    [CAPACITY];
    logic             w_alive [CAPACITY];
    logic             w_hit   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int LO = (g == 0) ? 0 : g - 1;
        localparam int HI = (g == CAPACITY - 1) ? 0 : g + 1;

        dset_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_count    (i_count),
            .i_lo_ent   (w_ent[LO]),
            .i_lo_gt    ((g == 0) ? 1'b0 : w_gt[LO]),
            .i_lo_alive ((g == 0) ? 1'b1 : w_alive[LO]),
            .i_hi_ent   (w_ent[HI]),
            .i_hi_alive ((g == CAPACITY - 1) ? 1'b0 : w_alive[HI]),
            .i_hi_hit   ((g == CAPACITY - 1) ? 1'b0 : w_hit[HI]),
            .o_ent      (w_ent[g]),
            .o_gt       (w_gt[g]),
            .o_alive    (w_alive[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign o_head_ent = w_ent[0];
    assign o_head_hit = w_hit[0];

endmodule

`default_nettype wire

FILE: design/depth_sorted_entry_table_top.sv
// Depth-sorted entry table: command sequencer, stream ports and the cell row.
// Accept to result word: insert via S_INSERT, remove via S_MARK then S_SWAP (skipped on an
// empty table), read via S_ROTATE; clear, unused, full and out-of-range read go to S_DONE.
// One command at a time; next word taken once the result is registered, later while an
// older result waits. Remove: odd-even compaction passes over occupied cells; read: one
// full rotation. Reset empties the table. Depends on dset_pkg and dset_chain.
`timescale 1ns / 1ps
`default_nettype none

module depth_sorted_entry_table_top #(
    parameter int CAPACITY = dset_pkg::DEF_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // command, entry_type, pos_x, pos_y, depth_key, read_index, zero pad
    input  wire logic [dset_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // entry_count, removed_count, table_full, read_valid, read_type, read_x,
    // read_y, read_depth, zero pad
    output logic [dset_pkg::M_DATA_W-1:0]      m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMPW  = (CNT_W > dset_pkg::RIDX_W) ? CNT_W : dset_pkg::RIDX_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_INSERT = 6'b000010,
        S_MARK   = 6'b000100,
        S_SWAP   = 6'b001000,
        S_ROTATE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic                            r_m_valid, n_m_valid;
    logic [dset_pkg::M_DATA_W-1:0]   r_m_data, n_m_data;
    dset_pkg::t_entry                r_ent, n_ent;
    logic                            r_use_type, n_use_type;
    logic [dset_pkg::RIDX_W-1:0]     r_ridx, n_ridx;
    logic [CNT_W-1:0]                r_step, n_step;
    logic [CNT_W-1:0]                r_removed, n_removed;
    logic                            r_full, n_full;
    logic                            r_rvalid, n_rvalid;
    dset_pkg::t_entry                r_rent, n_rent;

    dset_pkg::t_cell_ctl             w_ctl;
    dset_pkg::t_entry                w_head_ent;
    logic                            w_head_hit;
    logic                            w_accept;
    logic [dset_pkg::CMD_W-1:0]      w_cmd;
    logic [CNT_W-1:0]                w_rem_total;

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = s_axis_tdata[2:0];
    assign w_rem_total   = r_removed + CNT_W'(w_head_hit);

    always_comb begin
        w_ctl.op       = dset_pkg::CELL_HOLD;
        w_ctl.parity   = r_step[0];
        w_ctl.use_type = r_use_type;
        w_ctl.ent      = r_ent;
        case (r_state)
            S_INSERT: w_ctl.op = dset_pkg::CELL_INSERT;
            S_MARK:   w_ctl.op = dset_pkg::CELL_MARK;
            S_SWAP:   w_ctl.op = dset_pkg::CELL_SWAP;
            S_ROTATE: w_ctl.op = dset_pkg::CELL_ROTATE;
            default:  w_ctl.op = dset_pkg::CELL_HOLD;
        endcase
    end

    dset_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_count    (r_count),
        .o_head_ent (w_head_ent),
        .o_head_hit (w_head_hit)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_ent      = r_ent;
        n_use_type = r_use_type;
        n_ridx     = r_ridx;
        n_step     = r_step;
        n_removed  = r_removed;
        n_full     = r_full;
        n_rvalid   = r_rvalid;
        n_rent     = r_rent;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ent.kind  = s_axis_tdata[10:3];
                    n_ent.x     = s_axis_tdata[18:11];
                    n_ent.y     = s_axis_tdata[26:19];
                    n_ent.depth = s_axis_tdata[34:27];
                    n_ridx      = s_axis_tdata[43:35];
                    n_use_type  = 1'b0;
                    n_step      = '0;
                    n_removed   = '0;
                    n_full      = 1'b0;
                    n_rvalid    = 1'b0;
                    n_rent      = '0;
                    n_state     = S_DONE;
                    case (w_cmd)
                        dset_pkg::CMD_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_full = 1'b1;
                            end else begin
                                n_state = S_INSERT;
                            end
                        end
                        dset_pkg::CMD_REM_POS: begin
                            n_state = S_MARK;
                        end
                        dset_pkg::CMD_REM_TYPE: begin
                            n_use_type = 1'b1;
                            n_state    = S_MARK;
                        end
                        dset_pkg::CMD_CLEAR: begin
                            n_removed = r_count;
                            n_count   = '0;
                        end
                        dset_pkg::CMD_READ: begin
                            if (CMPW'(s_axis_tdata[43:35]) < CMPW'(r_count)) begin
                                n_state = S_ROTATE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_MARK: begin
                n_state = (r_count == '0) ? S_DONE : S_SWAP;
            end
            S_SWAP: begin
                n_removed = w_rem_total;
                n_step    = r_step + 1'b1;
                if (r_step == CNT_W'(r_count - 1'b1)) begin
                    n_count = r_count - w_rem_total;
                    n_state = S_DONE;
                end
            end
            S_ROTATE: begin
                if (CMPW'(r_step) == CMPW'(r_ridx)) begin
                    n_rent   = w_head_ent;
                    n_rvalid = 1'b1;
                end
                n_step = r_step + 1'b1;
                if (r_step == CNT_W'(CAPACITY - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {2'b00, r_rent.depth, r_rent.y, r_rent.x, r_rent.kind,
                                 r_rvalid, r_full,
                                 dset_pkg::OCNT_W'(r_removed), dset_pkg::OCNT_W'(r_count)};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data   <= n_m_data;
        r_ent      <= n_ent;
        r_use_type <= n_use_type;
        r_ridx     <= n_ridx;
        r_step     <= n_step;
        r_removed  <= n_removed;
        r_full     <= n_full;
        r_rvalid   <= n_rvalid;
        r_rent     <= n_rent;
    end

endmodule

`default_nettype wire

FILE: design/dset_chk.sv
// Port-level checks for the depth-sorted entry table, bound to the top level.
// Depends on dset_pkg and depth_sorted_entry_table_top.
`timescale 1ns / 1ps
`default_nettype none

module dset_chk #(
    parameter int CAPACITY = dset_pkg::DEF_CAPACITY
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [dset_pkg::M_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[9:0]) <= CAPACITY))
        else $error("entry count above capacity");

    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> !m_axis_tdata[20] &&
            (m_axis_tdata[19:10] == 10'd0))
        else $error("read result carries remove or full status");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[21] |-> (m_axis_tdata[53:22] == 32'd0))
        else $error("read fields nonzero without a valid read");

endmodule

bind depth_sorted_entry_table_top dset_chk #(
    .CAPACITY (CAPACITY)
) u_dset_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/depth_sorted_entry_table_top_tb.sv
// Self-checking testbench for depth_sorted_entry_table_top: drives command words on the
// input stream, predicts each status word from a shadow copy of the sorted table, checks.
// Depends on dset_pkg and the table RTL only.
`timescale 1ns / 1ps

module depth_sorted_entry_table_top_tb;
    import dset_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int ITEM_TOTAL = 1650;
    localparam int PRINT_MAX  = 60;

    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;

    typedef struct packed {
        logic [RIDX_W-1:0] read_index;
        logic [BYTE_W-1:0] depth_key;
        logic [BYTE_W-1:0] pos_y;
        logic [BYTE_W-1:0] pos_x;
        logic [BYTE_W-1:0] entry_type;
        logic [CMD_W-1:0]  command;
    } cmd_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_depth;
        logic [BYTE_W-1:0] read_y;
        logic [BYTE_W-1:0] read_x;
        logic [BYTE_W-1:0] read_type;
        logic              read_valid;
        logic              table_full;
        logic [OCNT_W-1:0] removed_count;
        logic [OCNT_W-1:0] entry_count;
    } status_word_t;

    typedef struct {
        cmd_word_t word;
        bit        drain;
    } cmd_item_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // command, entry_type, pos_x, pos_y, depth_key, read_index, zero pad
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // entry_count, removed_count, table_full, read_valid, read_type, read_x,
    // read_y, read_depth, zero pad
    logic [M_DATA_W-1:0] m_axis_tdata;

    t_entry       shadow_slots [CAPACITY];
    int           shadow_fill = 0;
    cmd_item_t    cmd_backlog [$];
    status_word_t reply_forecast [$];
    cmd_word_t    cur_word;
    cmd_item_t    nxt_item;
    status_word_t seen_status;
    status_word_t want_status;
    int           sent_count  = 0;
    int           done_count  = 0;
    int           fault_count = 0;
    int           issued      = 0;
    int           send_gap    = 0;
    int           sink_stall  = 0;
    bit           took;
    bit           drive_steady = 1'b0;
    bit           sink_steady  = 1'b0;
    bit           drain_next   = 1'b0;
    bit           fill_done    = 1'b0;

    depth_sorted_entry_table_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic status_word_t apply_command(cmd_word_t w);
        status_word_t r;
        int           p;
        int           rd;
        int           wr;
        bit           hit;
        r = '0;
        case (w.command)
            CMD_INSERT: begin
                if (shadow_fill >= CAPACITY) begin
                    r.table_full = 1'b1;
                end else begin
                    p = shadow_fill;
                    while (p > 0 && shadow_slots[p-1].depth > w.depth_key) begin
                        shadow_slots[p] = shadow_slots[p-1];
                        p--;
                    end
                    shadow_slots[p].kind  = w.entry_type;
                    shadow_slots[p].x     = w.pos_x;
                    shadow_slots[p].y     = w.pos_y;
                    shadow_slots[p].depth = w.depth_key;
                    shadow_fill++;
                end
            end
            CMD_REM_POS, CMD_REM_TYPE: begin
                wr = 0;
                for (rd = 0; rd < shadow_fill; rd++) begin
                    hit = shadow_slots[rd].x == w.pos_x && shadow_slots[rd].y == w.pos_y &&
                          (w.command != CMD_REM_TYPE || shadow_slots[rd].kind == w.entry_type);
                    if (!hit) begin
                        shadow_slots[wr] = shadow_slots[rd];
                        wr++;
                    end
                end
                r.removed_count = OCNT_W'(shadow_fill - wr);
                shadow_fill = wr;
            end
            CMD_CLEAR: begin
                r.removed_count = OCNT_W'(shadow_fill);
                shadow_fill = 0;
            end
            CMD_READ: begin
                if (int'(w.read_index) < shadow_fill) begin
                    r.read_valid = 1'b1;
                    r.read_type  = shadow_slots[w.read_index].kind;
                    r.read_x     = shadow_slots[w.read_index].x;
                    r.read_y     = shadow_slots[w.read_index].y;
                    r.read_depth = shadow_slots[w.read_index].depth;
                end
            end
            default: ;
        endcase
        r.entry_count = OCNT_W'(shadow_fill);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (fault_count < PRINT_MAX)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    // driver: load the next word once the bus is free, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            sent_count    <= 0;
            send_gap = 0;
            shadow_fill = 0;
        end else begin
            took = s_axis_tvalid && s_axis_tready;
            if (took) begin
                reply_forecast.push_back(apply_command(cur_word));
                sent_count <= sent_count + 1;
                if ($urandom_range(0, 49) == 0) drive_steady = !drive_steady;
            end
            if (!s_axis_tvalid || took) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap--;
                end else if (cmd_backlog.size() > 0 && !(cmd_backlog[0].drain &&
                             (took || sent_count != done_count))) begin
                    nxt_item = cmd_backlog.pop_front();
                    cur_word = nxt_item.word;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_DATA_W'(nxt_item.word);
                    send_gap = pick_gap(drive_steady);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted status word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            done_count    <= 0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                done_count <= done_count + 1;
                seen_status = status_word_t'(m_axis_tdata[$bits(status_word_t)-1:0]);
                if (reply_forecast.size() == 0) begin
                    if (fault_count < PRINT_MAX)
                        $display("%0t: unexpected word, expected none, got %h",
                                 $time, seen_status);
                    fault_count++;
                end else begin
                    want_status = reply_forecast.pop_front();
                    check_field("entry_count", want_status.entry_count,
                                seen_status.entry_count);
                    check_field("removed_count", want_status.removed_count,
                                seen_status.removed_count);
                    check_field("table_full", want_status.table_full,
                                seen_status.table_full);
                    check_field("read_valid", want_status.read_valid,
                                seen_status.read_valid);
                    check_field("read_type", want_status.read_type, seen_status.read_type);
                    check_field("read_x", want_status.read_x, seen_status.read_x);
                    check_field("read_y", want_status.read_y, seen_status.read_y);
                    check_field("read_depth", want_status.read_depth,
                                seen_status.read_depth);
                end
                sink_stall = pick_gap(sink_steady);
                if ($urandom_range(0, 49) == 0) sink_steady = !sink_steady;
            end
            if (sink_stall > 0) begin
                m_axis_tready <= 1'b0;
                sink_stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_room();
        while (cmd_backlog.size() >= 2) @(negedge i_clk);
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] kind,
                            input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] y,
                            input logic [BYTE_W-1:0] depth, input logic [RIDX_W-1:0] idx);
        cmd_item_t it;
        wait_room();
        it.word.command    = op;
        it.word.entry_type = kind;
        it.word.pos_x      = x;
        it.word.pos_y      = y;
        it.word.depth_key  = depth;
        it.word.read_index = idx;
        it.drain = drain_next || ($urandom_range(0, 99) == 0);
        drain_next = 1'b0;
        cmd_backlog.push_back(it);
        issued++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_small();
        return ($urandom_range(0, 4) != 0) ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_depth();
        return ($urandom_range(0, 1) != 0) ? BYTE_W'($urandom_range(0, 7)) : BYTE_W'($urandom);
    endfunction

    // aim a removal at a live entry most of the time
    task automatic pick_target(output logic [BYTE_W-1:0] kind, output logic [BYTE_W-1:0] x,
                               output logic [BYTE_W-1:0] y);
        int k;
        if (shadow_fill > 0 && $urandom_range(0, 3) != 0) begin
            k    = $urandom_range(0, shadow_fill - 1);
            kind = shadow_slots[k].kind;
            x    = shadow_slots[k].x;
            y    = shadow_slots[k].y;
            if ($urandom_range(0, 3) == 0) kind = pick_small();
        end else begin
            kind = pick_small();
            x    = pick_small();
            y    = pick_small();
        end
    endtask

    function automatic logic [RIDX_W-1:0] pick_index();
        if (shadow_fill > 0 && $urandom_range(0, 4) != 0)
            return RIDX_W'($urandom_range(0, shadow_fill - 1));
        return RIDX_W'($urandom);
    endfunction

    task automatic gen_mixed(input int len);
        int                n;
        int                r;
        logic [BYTE_W-1:0] kind;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        for (n = 0; n < len; n++) begin
            wait_room();
            r = $urandom_range(0, 99);
            if (r < 42) begin
                push_cmd(CMD_INSERT, pick_small(), pick_small(), pick_small(), pick_depth(),
                         RIDX_W'($urandom));
            end else if (r < 60) begin
                push_cmd(CMD_READ, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom), pick_index());
            end else if (r < 84) begin
                pick_target(kind, x, y);
                push_cmd((r < 72) ? CMD_REM_POS : CMD_REM_TYPE, kind, x, y,
                         BYTE_W'($urandom), RIDX_W'($urandom));
            end else if (r < 86) begin
                push_cmd(CMD_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom), RIDX_W'($urandom));
            end else if (r < 92) begin
                push_cmd(CMD_W'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C)), BYTE_W'($urandom),
                         BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         RIDX_W'($urandom));
            end else begin
                push_cmd(CMD_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom), BYTE_W'($urandom), RIDX_W'($urandom));
            end
        end
    endtask

    // grow the table to capacity, overflow it, then read at both ends and remove targeted entries
    task automatic gen_fill();
        int                n;
        logic [BYTE_W-1:0] kind;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        while (shadow_fill < CAPACITY) begin
            wait_room();
            if ($urandom_range(0, 24) == 0)
                push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, pick_index());
            else
                push_cmd(CMD_INSERT, pick_small(), pick_small(), pick_small(), pick_depth(),
                         RIDX_W'($urandom));
        end
        for (n = 0; n < 6; n++)
            push_cmd(CMD_INSERT, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     BYTE_W'($urandom), RIDX_W'($urandom));
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, RIDX_W'(CAPACITY - 1));
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, RIDX_W'(CAPACITY - 2));
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, '0);
        wait_room();
        pick_target(kind, x, y);
        push_cmd(CMD_REM_TYPE, kind, x, y, 8'h00, '0);
        wait_room();
        pick_target(kind, x, y);
        push_cmd(CMD_REM_POS, kind, x, y, 8'h00, '0);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, RIDX_W'(CAPACITY - 1));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: out-of-range read, removal with no match, clear, spare codes
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
        push_cmd(CMD_REM_POS, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
        push_cmd(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
        push_cmd(CMD_UNUSED_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF);
        push_cmd(CMD_UNUSED_A + 3'd1, 8'h55, 8'hAA, 8'h55, 8'hAA, 9'h155);
        push_cmd(CMD_UNUSED_C, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
        // equal keys must keep arrival order
        push_cmd(CMD_INSERT, 8'hFF, 8'h00, 8'hFF, 8'h80, 9'd0);
        push_cmd(CMD_INSERT, 8'h00, 8'hFF, 8'h00, 8'h80, 9'h1FF);
        push_cmd(CMD_INSERT, 8'h5A, 8'h12, 8'h34, 8'h00, 9'd0);
        push_cmd(CMD_INSERT, 8'hA5, 8'h12, 8'h34, 8'hFF, 9'd0);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd1);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd2);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd3);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd4);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'h1FF);
        push_cmd(CMD_REM_TYPE, 8'h01, 8'h00, 8'hFF, 8'h00, 9'd0);
        push_cmd(CMD_REM_TYPE, 8'hFF, 8'h00, 8'hFF, 8'h00, 9'd0);
        push_cmd(CMD_REM_POS, 8'h00, 8'h12, 8'h34, 8'h00, 9'd0);
        push_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
        push_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);

        // hold off until the directed words have all answered
        drain_next = 1'b1;
        while (issued < ITEM_TOTAL) begin
            if (!fill_done && issued > 350) begin
                gen_fill();
                fill_done = 1'b1;
            end else begin
                gen_mixed($urandom_range(30, 120));
            end
        end

        while (cmd_backlog.size() != 0 || s_axis_tvalid || done_count != sent_count)
            @(negedge i_clk);
        repeat (CAPACITY + 20) @(negedge i_clk);
        if (fault_count == 0)
            $display("depth_sorted_entry_table_top_tb: done, clean");
        else
            $display("depth_sorted_entry_table_top_tb: done, errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("depth_sorted_entry_table_top_tb: done, errors");
        $finish;
    end

endmodule
